FILE: design/csft_pkg.sv
`default_nettype none

package csft_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_IDX_W = 6;
    localparam int ID_W       = 16;
    localparam int PDU_W      = 3;
    localparam int CNT_W      = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_APPLY   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CS_IDLE          = 3'd0,
        CS_SETUP_PENDING = 3'd1,
        CS_PROCEEDING    = 3'd2,
        CS_CONNECTED     = 3'd3,
        CS_TX_GRANTED    = 3'd4,
        CS_RELEASING     = 3'd5
    } call_state_t;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_NOT_FOUND = 3'd1,
        RS_DUPLICATE = 3'd2,
        RS_FULL      = 3'd3,
        RS_DROPPED   = 3'd4
    } status_t;

    localparam logic [PDU_W-1:0] PDU_SETUP      = 3'd0;
    localparam logic [PDU_W-1:0] PDU_PROCEEDING = 3'd1;
    localparam logic [PDU_W-1:0] PDU_CONNECT    = 3'd2;
    localparam logic [PDU_W-1:0] PDU_TX_DEMAND  = 3'd3;
    localparam logic [PDU_W-1:0] PDU_TX_GRANTED = 3'd4;
    localparam logic [PDU_W-1:0] PDU_RELEASE    = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_MATCH = 2'd1,
        S_SEL   = 2'd2,
        S_UPD   = 2'd3
    } fsm_t;

    // write port shared by all cells
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic               busy;
        logic [ID_W-1:0]    id;
        call_state_t        state;
    } slot_wr_t;

    // priority token handed from cell to cell
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } scan_t;

    typedef struct packed {
        call_state_t next_state;
        logic        free;
        status_t     status;
        logic        inc_drop;
        logic        inc_setup;
        logic        inc_connect;
        logic        inc_grant;
        logic        inc_release;
    } apply_t;

    function automatic apply_t apply_pdu(call_state_t st, logic [PDU_W-1:0] pdu, logic dir);
        apply_t r;
        r.next_state  = st;
        r.free        = 1'b0;
        r.status      = RS_DROPPED;
        r.inc_drop    = 1'b1;
        r.inc_setup   = 1'b0;
        r.inc_connect = 1'b0;
        r.inc_grant   = 1'b0;
        r.inc_release = 1'b0;
        case (pdu)
            PDU_SETUP:
            begin
                // an uplink setup still counts, with a drop unless the slot is already setup-pending
                r.inc_drop   = dir && (st != CS_SETUP_PENDING);
                r.inc_setup  = 1'b1;
                r.next_state = CS_SETUP_PENDING;
                r.status     = RS_OK;
            end
            PDU_PROCEEDING:
            begin
                if (st == CS_SETUP_PENDING)
                begin
                    r.next_state = CS_PROCEEDING;
                    r.status     = RS_OK;
                    r.inc_drop   = 1'b0;
                end
            end
            PDU_CONNECT:
            begin
                if (st == CS_PROCEEDING || st == CS_SETUP_PENDING)
                begin
                    r.next_state  = CS_CONNECTED;
                    r.status      = RS_OK;
                    r.inc_drop    = 1'b0;
                    r.inc_connect = 1'b1;
                end
            end
            PDU_TX_DEMAND:
            begin
                if (st == CS_CONNECTED)
                begin
                    r.next_state = CS_TX_GRANTED;
                    r.status     = RS_OK;
                    r.inc_drop   = 1'b0;
                    r.inc_grant  = 1'b1;
                end
            end
            PDU_TX_GRANTED:
            begin
                if (st == CS_CONNECTED || st == CS_TX_GRANTED)
                begin
                    r.next_state = CS_TX_GRANTED;
                    r.status     = RS_OK;
                    r.inc_drop   = 1'b0;
                    r.inc_grant  = 1'b1;
                end
            end
            PDU_RELEASE:
            begin
                if (st == CS_RELEASING)
                begin
                    r.next_state  = CS_IDLE;
                    r.free        = 1'b1;
                    r.status      = RS_OK;
                    r.inc_drop    = 1'b0;
                    r.inc_release = 1'b1;
                end
                else if (st != CS_IDLE)
                begin
                    r.next_state  = CS_RELEASING;
                    r.status      = RS_OK;
                    r.inc_drop    = 1'b0;
                    r.inc_release = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/csft_cell.sv
`default_nettype none

module csft_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [csft_pkg::IDX_W-1:0]    my_idx,
    input  wire logic [csft_pkg::ID_W-1:0]     req_id,
    input  wire logic                          sample,
    input  wire csft_pkg::slot_wr_t            wr,
    input  wire csft_pkg::scan_t               chain_in,
    output csft_pkg::scan_t                    chain_out,
    output logic                               first_hit,
    output logic                               first_free,
    output csft_pkg::call_state_t              slot_state
);

    logic                       busy_reg;
    logic [csft_pkg::ID_W-1:0]  id_reg;
    csft_pkg::call_state_t      state_reg;
    logic                       hit_reg;
    logic                       free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            id_reg    <= '0;
            state_reg <= csft_pkg::CS_IDLE;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en && wr.idx == my_idx)
            begin
                busy_reg  <= wr.busy;
                id_reg    <= wr.id;
                state_reg <= wr.state;
            end
            if (sample)
            begin
                hit_reg  <= busy_reg && (id_reg == req_id);
                free_reg <= !busy_reg;
            end
        end
    end

    // lowest index wins: pass on whether anyone below already matched
    assign first_hit           = hit_reg && !chain_in.hit_seen;
    assign first_free          = free_reg && !chain_in.free_seen;
    assign chain_out.hit_seen  = chain_in.hit_seen || hit_reg;
    assign chain_out.free_seen = chain_in.free_seen || free_reg;
    assign slot_state          = state_reg;

endmodule

`default_nettype wire

FILE: design/call_slot_table_fsm_core.sv
`default_nettype none

// call slot table: a row of 16 slot cells, each holding busy mark, call id and call state.
// every request goes through these steps: accept in idle, all cells compare their id in parallel,
// a priority token ripples along the row of cells to pick the lowest hit and lowest free
// slot, then the controller updates at most one slot and the counters and loads the result
// register. the next item is taken while a finished result still waits in the output
// register; the update step holds only if the previous result has not been taken.
// the table comes out of reset empty at once, no clearing pass. the five 32-bit
// counters wrap and are reported as they stand after the request.

module call_slot_table_fsm_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // call_id[15:0], pdu_code[18:16], direction[19], zeros
    input  wire logic [1:0]   s_tuser,   // operation[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [175:0]      m_tdata,   // slot_index[5:0], call_state[8:6], drop_total[40:9],
                                         // setup_total[72:41], connect_total[104:73],
                                         // grant_total[136:105], release_total[168:137], zeros
    output logic [2:0]        m_tuser    // status[2:0]
);

    localparam int N  = csft_pkg::NUM_SLOTS;
    localparam int IW = csft_pkg::IDX_W;

    // fsm
    csft_pkg::fsm_t state_reg, state_next;

    // captured request
    csft_pkg::op_t                  req_op_reg;
    logic [csft_pkg::ID_W-1:0]      req_id_reg;
    logic [csft_pkg::PDU_W-1:0]     req_pdu_reg;
    logic                           req_dir_reg;

    // selection results
    logic                           hit_found_reg;
    logic [IW-1:0]                  hit_idx_reg;
    csft_pkg::call_state_t          hit_state_reg;
    logic                           free_found_reg;
    logic [IW-1:0]                  free_idx_reg;

    // counters
    logic [csft_pkg::CNT_W-1:0]     drop_cnt_reg;
    logic [csft_pkg::CNT_W-1:0]     setup_cnt_reg;
    logic [csft_pkg::CNT_W-1:0]     connect_cnt_reg;
    logic [csft_pkg::CNT_W-1:0]     grant_cnt_reg;
    logic [csft_pkg::CNT_W-1:0]     release_cnt_reg;

    // result register (counters feed the output directly: they only move when
    // the previous result leaves)
    logic                           out_valid_reg;
    csft_pkg::status_t              out_status_reg;
    logic [csft_pkg::SLOT_IDX_W-1:0] out_idx_reg;
    csft_pkg::call_state_t          out_cst_reg;

    // control
    logic                           sample;
    logic                           sel_load;
    logic                           commit;

    // cell row
    csft_pkg::scan_t                chain [0:N];
    logic [N-1:0]                   first_hit;
    logic [N-1:0]                   first_free;
    csft_pkg::call_state_t          cell_state [0:N-1];
    csft_pkg::slot_wr_t             wr;

    // selection, combinational across the row
    logic                           sel_hit_found;
    logic                           sel_free_found;
    logic [IW-1:0]                  sel_hit_idx;
    logic [IW-1:0]                  sel_free_idx;
    csft_pkg::call_state_t          sel_hit_state;

    // decision
    csft_pkg::apply_t               ap;
    csft_pkg::slot_wr_t             dec_wr;
    csft_pkg::status_t              dec_status;
    logic [IW-1:0]                  dec_idx;
    csft_pkg::call_state_t          dec_cst;
    logic                           dec_drop;
    logic                           dec_setup;
    logic                           dec_connect;
    logic                           dec_grant;
    logic                           dec_release;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            csft_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .my_idx     (IW'(g)),
                .req_id     (req_id_reg),
                .sample     (sample),
                .wr         (wr),
                .chain_in   (chain[g]),
                .chain_out  (chain[g+1]),
                .first_hit  (first_hit[g]),
                .first_free (first_free[g]),
                .slot_state (cell_state[g])
            );
        end
    endgenerate

    // one-hot to index and state
    always_comb
    begin
        logic [2:0] st_bits;
        sel_hit_idx  = '0;
        sel_free_idx = '0;
        st_bits      = '0;
        for (int i = 0; i < N; i++)
        begin
            if (first_hit[i])
            begin
                sel_hit_idx = sel_hit_idx | IW'(i);
                st_bits     = st_bits | cell_state[i];
            end
            if (first_free[i])
            begin
                sel_free_idx = sel_free_idx | IW'(i);
            end
        end
        sel_hit_state  = csft_pkg::call_state_t'(st_bits);
        sel_hit_found  = chain[N].hit_seen;
        sel_free_found = chain[N].free_seen;
    end

    // what the request does to the table and counters
    always_comb
    begin
        ap          = csft_pkg::apply_pdu(hit_state_reg, req_pdu_reg, req_dir_reg);
        dec_wr      = '0;
        dec_status  = csft_pkg::RS_OK;
        dec_idx     = '0;
        dec_cst     = csft_pkg::CS_IDLE;
        dec_drop    = 1'b0;
        dec_setup   = 1'b0;
        dec_connect = 1'b0;
        dec_grant   = 1'b0;
        dec_release = 1'b0;
        case (req_op_reg)
            csft_pkg::OP_LOOKUP:
            begin
                if (hit_found_reg)
                begin
                    dec_idx = hit_idx_reg;
                    dec_cst = hit_state_reg;
                end
                else
                begin
                    dec_status = csft_pkg::RS_NOT_FOUND;
                end
            end
            csft_pkg::OP_ALLOC:
            begin
                if (hit_found_reg)
                begin
                    dec_status = csft_pkg::RS_DUPLICATE;
                    dec_drop   = 1'b1;
                end
                else if (free_found_reg)
                begin
                    dec_idx      = free_idx_reg;
                    dec_cst      = csft_pkg::CS_SETUP_PENDING;
                    dec_wr.en    = 1'b1;
                    dec_wr.idx   = free_idx_reg;
                    dec_wr.busy  = 1'b1;
                    dec_wr.id    = req_id_reg;
                    dec_wr.state = csft_pkg::CS_SETUP_PENDING;
                end
                else
                begin
                    dec_status = csft_pkg::RS_FULL;
                end
            end
            csft_pkg::OP_APPLY:
            begin
                if (hit_found_reg)
                begin
                    dec_status   = ap.status;
                    dec_idx      = hit_idx_reg;
                    dec_cst      = ap.next_state;
                    dec_drop     = ap.inc_drop;
                    dec_setup    = ap.inc_setup;
                    dec_connect  = ap.inc_connect;
                    dec_grant    = ap.inc_grant;
                    dec_release  = ap.inc_release;
                    dec_wr.en    = 1'b1;
                    dec_wr.idx   = hit_idx_reg;
                    dec_wr.busy  = !ap.free;
                    dec_wr.id    = ap.free ? '0 : req_id_reg;
                    dec_wr.state = ap.next_state;
                end
                else
                begin
                    dec_status = csft_pkg::RS_NOT_FOUND;
                    dec_drop   = 1'b1;
                end
            end
            csft_pkg::OP_RELEASE:
            begin
                if (hit_found_reg)
                begin
                    dec_idx      = hit_idx_reg;
                    dec_wr.en    = 1'b1;
                    dec_wr.idx   = hit_idx_reg;
                    dec_wr.busy  = 1'b0;
                    dec_wr.id    = '0;
                    dec_wr.state = csft_pkg::CS_IDLE;
                end
                else
                begin
                    dec_status = csft_pkg::RS_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
    end

    // slot write only on the commit cycle
    always_comb
    begin
        wr    = dec_wr;
        wr.en = dec_wr.en && commit;
    end

    // fsm next state and strobes
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        sample     = 1'b0;
        sel_load   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            csft_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = csft_pkg::S_MATCH;
                end
            end
            csft_pkg::S_MATCH:
            begin
                sample     = 1'b1;
                state_next = csft_pkg::S_SEL;
            end
            csft_pkg::S_SEL:
            begin
                sel_load   = 1'b1;
                state_next = csft_pkg::S_UPD;
            end
            csft_pkg::S_UPD:
            begin
                // wait for the output register to empty
                if (!out_valid_reg || m_tready)
                begin
                    commit     = 1'b1;
                    state_next = csft_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = csft_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csft_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request and selection payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_op_reg  <= csft_pkg::op_t'(s_tuser);
            req_id_reg  <= s_tdata[15:0];
            req_pdu_reg <= s_tdata[18:16];
            req_dir_reg <= s_tdata[19];
        end
        if (sel_load)
        begin
            hit_found_reg  <= sel_hit_found;
            hit_idx_reg    <= sel_hit_idx;
            hit_state_reg  <= sel_hit_state;
            free_found_reg <= sel_free_found;
            free_idx_reg   <= sel_free_idx;
        end
        if (commit)
        begin
            out_status_reg <= dec_status;
            out_idx_reg    <= csft_pkg::SLOT_IDX_W'(dec_idx);
            out_cst_reg    <= dec_cst;
        end
    end

    // counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_cnt_reg    <= '0;
            setup_cnt_reg   <= '0;
            connect_cnt_reg <= '0;
            grant_cnt_reg   <= '0;
            release_cnt_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                drop_cnt_reg    <= drop_cnt_reg + csft_pkg::CNT_W'(dec_drop);
                setup_cnt_reg   <= setup_cnt_reg + csft_pkg::CNT_W'(dec_setup);
                connect_cnt_reg <= connect_cnt_reg + csft_pkg::CNT_W'(dec_connect);
                grant_cnt_reg   <= grant_cnt_reg + csft_pkg::CNT_W'(dec_grant);
                release_cnt_reg <= release_cnt_reg + csft_pkg::CNT_W'(dec_release);
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, release_cnt_reg, grant_cnt_reg, connect_cnt_reg,
                       setup_cnt_reg, drop_cnt_reg, out_cst_reg, out_idx_reg};

    // at most one cell claims the lowest hit and the lowest free slot
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_hit) && $onehot0(first_free))
        else $error("more than one cell selected");

    // drop, setup and release counters move only on the commit cycle
    a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> ($stable(drop_cnt_reg) && $stable(setup_cnt_reg)
                     && $stable(release_cnt_reg)))
        else $error("counter changed outside commit");

    // an accepted item starts the compare step next
    a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == csft_pkg::S_MATCH)
        else $error("accepted item did not start compare");

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten");

endmodule

`default_nettype wire
